FILE: sv/pcmq_pkg.sv
// pcmq_pkg: shared constants for the per-client message queue block.
// Field widths, operation codes and status codes. No dependencies.
package pcmq_pkg;

	localparam int PID_W    = 32;
	localparam int MSG_W    = 64;
	localparam int ALIVE_W  = 16;
	localparam int STATUS_W = 3;

	typedef logic [STATUS_W-1:0] status_t;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_PID_ZERO = 3'd1;
	localparam status_t ST_NO_SLOT  = 3'd2;
	localparam status_t ST_FULL     = 3'd3;
	localparam status_t ST_UNKNOWN  = 3'd4;
	localparam status_t ST_EMPTY    = 3'd5;

endpackage

FILE: sv/pcmq_req_if.sv
// pcmq_req_if: request channel (valid/ready) for the message queue block.
// Depends on pcmq_pkg for field widths.
interface pcmq_req_if;
	logic                            valid;
	logic                            ready;
	logic                            op;
	logic [pcmq_pkg::PID_W-1:0]      pid;
	logic [pcmq_pkg::MSG_W-1:0]      message;
	logic [pcmq_pkg::ALIVE_W-1:0]    alive_mask;

	modport source (output valid, op, pid, message, alive_mask, input ready);
	modport sink   (input valid, op, pid, message, alive_mask, output ready);
endinterface

FILE: sv/pcmq_rsp_if.sv
// pcmq_rsp_if: response channel (valid/ready) for the message queue block.
// Depends on pcmq_pkg for field widths and the status type.
interface pcmq_rsp_if;
	logic                         valid;
	logic                         ready;
	pcmq_pkg::status_t            status;
	logic [pcmq_pkg::MSG_W-1:0]   message_out;

	modport source (output valid, status, message_out, input ready);
	modport sink   (input valid, status, message_out, output ready);
endinterface

FILE: sv/pcmq_slot_table.sv
// pcmq_slot_table: per-slot owner pid and ring pointers, one write and one
// registered read port; per-slot valid bits make unwritten slots read as free.
// Depends on pcmq_pkg.
module pcmq_slot_table #(
	parameter int SLOTS = 16,
	parameter int PW    = 5,
	parameter int SW    = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic                          clr,
	input  logic [SW-1:0]                 waddr,
	input  logic [pcmq_pkg::PID_W-1:0]    wowner,
	input  logic [PW-1:0]                 wwptr,
	input  logic [PW-1:0]                 wrptr,
	input  logic [SW-1:0]                 raddr,
	output logic [pcmq_pkg::PID_W-1:0]    rowner,
	output logic [PW-1:0]                 rwptr,
	output logic [PW-1:0]                 rrptr
);

	localparam int EW = pcmq_pkg::PID_W + 2 * PW;

	logic [EW-1:0]    mem [SLOTS];
	logic [SLOTS-1:0] vld_q;
	logic [EW-1:0]    rdata_q;
	logic             rvld_q;

	always_ff @(posedge clk) begin
		if (we && !clr) begin
			mem[waddr] <= {wowner, wwptr, wrptr};
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= !clr;
			end
			rvld_q <= vld_q[raddr];
		end
	end

	// a slot never written, or freed, reads as owner zero with both pointers zero
	always_comb begin
		if (rvld_q) begin
			rowner = rdata_q[EW-1 -: pcmq_pkg::PID_W];
			rwptr  = rdata_q[2*PW-1 -: PW];
			rrptr  = rdata_q[PW-1:0];
		end else begin
			rowner = '0;
			rwptr  = '0;
			rrptr  = '0;
		end
	end

endmodule

FILE: sv/pcmq_msg_ram.sv
// pcmq_msg_ram: message store for all rings, one write port and one
// registered read port. Contents undefined until written. Depends on nothing.
module pcmq_msg_ram #(
	parameter int DEPTH    = 512,
	parameter int AW       = 9,
	parameter int MSG_BITS = 64
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  logic [MSG_BITS-1:0] wdata,
	input  logic                re,
	input  logic [AW-1:0]       raddr,
	output logic [MSG_BITS-1:0] rdata
);

	logic [MSG_BITS-1:0] mem [DEPTH];
	logic [MSG_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/per_client_message_queues_top.sv
// per_client_message_queues_top: keyed multi-queue sequencer with slot scan.
// Depends on pcmq_pkg, pcmq_req_if, pcmq_rsp_if, pcmq_slot_table, pcmq_msg_ram.
//
//   channel | dir | fields                              | handshake
//   req     | in  | op, pid, message, alive_mask        | valid/ready
//   rsp     | out | status, message_out                 | valid/ready
//
// One request at a time. Lookup scans the slot table one slot per cycle
// and stops at the matching slot; a push with no matching pid scans again to
// free dead slots and pick the lowest free one. A request with pid zero is
// answered without a scan. Reset clears the slot valid bits at once; ring
// contents need no clearing. req.ready is low from acceptance until the
// response transaction completes.
module per_client_message_queues_top #(
	parameter int SLOTS      = 16,
	parameter int RING_DEPTH = 32,
	parameter int MSG_BITS   = 64
) (
	input logic            clk,
	input logic            arst_n,
	pcmq_req_if.sink       req,
	pcmq_rsp_if.source     rsp
);

	localparam int PW    = $clog2(RING_DEPTH);
	localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW    = $clog2(SLOTS + 1);
	localparam int DEPTH = SLOTS * RING_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_MATCH   = 3'd1;
	localparam logic [2:0] S_RECLAIM = 3'd2;
	localparam logic [2:0] S_ACT     = 3'd3;
	localparam logic [2:0] S_POPWAIT = 3'd4;
	localparam logic [2:0] S_OUT     = 3'd5;

	logic [2:0]                       state_q;
	logic                             op_q;
	logic [pcmq_pkg::PID_W-1:0]       pid_q;
	logic [MSG_BITS-1:0]              msg_q;
	logic [pcmq_pkg::ALIVE_W-1:0]     alive_q;
	logic [CW-1:0]                    idx_q;
	logic                             pend_q;
	logic [SW-1:0]                    pidx_q;
	logic [SW-1:0]                    slot_q;
	logic                             found_q;
	logic [PW-1:0]                    wptr_q;
	logic [PW-1:0]                    rptr_q;
	pcmq_pkg::status_t                status_q;
	logic [pcmq_pkg::MSG_W-1:0]       msg_out_q;

	logic                             scanning;
	logic                             issue;
	logic                             rescan;
	logic [SW-1:0]                    raddr;
	logic [pcmq_pkg::PID_W-1:0]       rowner;
	logic [PW-1:0]                    rwptr;
	logic [PW-1:0]                    rrptr;
	logic                             last;
	logic                             has_alive;
	logic                             dead;
	logic                             free_now;
	logic                             st_we;
	logic                             st_clr;
	logic [SW-1:0]                    st_waddr;
	logic [PW-1:0]                    st_wwptr;
	logic [PW-1:0]                    st_wrptr;
	logic [PW-1:0]                    wnext;
	logic [PW-1:0]                    rnext;
	logic                             full;
	logic                             empty;
	logic [AW-1:0]                    slot_base;
	logic                             ram_we;
	logic                             ram_re;
	logic [MSG_BITS-1:0]              ram_rdata;
	logic [pcmq_pkg::MSG_W-1:0]       ram_ext;
	logic [6:0]                       pidx_ext;

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = (state_q == S_OUT);
	assign rsp.status = status_q;
	assign rsp.message_out = msg_out_q;

	assign scanning = (state_q == S_MATCH) || (state_q == S_RECLAIM);
	assign issue    = scanning && (idx_q < CW'(SLOTS));
	assign raddr    = issue ? idx_q[SW-1:0] : '0;
	assign last     = (pidx_q == SW'(SLOTS - 1));
	// lookup missed on the last slot: restart the scan for reclaiming
	assign rescan   = (state_q == S_MATCH) && pend_q && (rowner != pid_q) && last;

	// only the first sixteen slots have an alive bit; the rest count as alive
	assign pidx_ext  = 7'(pidx_q);
	assign has_alive = (pidx_ext < 7'd16);
	assign dead      = (rowner != '0) && has_alive && !alive_q[pidx_ext[3:0]];
	assign free_now  = (rowner == '0) || dead;

	assign wnext = (wptr_q == PW'(RING_DEPTH - 1)) ? '0 : wptr_q + PW'(1);
	assign rnext = (rptr_q == PW'(RING_DEPTH - 1)) ? '0 : rptr_q + PW'(1);
	assign full  = (wnext == rptr_q);
	assign empty = (rptr_q == wptr_q);

	assign slot_base = AW'(slot_q) * AW'(RING_DEPTH);

	always_comb begin
		st_we    = 1'b0;
		st_clr   = 1'b0;
		st_waddr = slot_q;
		st_wwptr = wptr_q;
		st_wrptr = rptr_q;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		if (state_q == S_RECLAIM && pend_q && dead) begin
			st_we    = 1'b1;
			st_clr   = 1'b1;
			st_waddr = pidx_q;
		end else if (state_q == S_ACT) begin
			if (op_q == pcmq_pkg::OP_PUSH) begin
				if (!full) begin
					st_we    = 1'b1;
					st_wwptr = wnext;
					ram_we   = 1'b1;
				end
			end else if (!empty) begin
				st_we    = 1'b1;
				st_wrptr = rnext;
				ram_re   = 1'b1;
			end
		end
	end

	always_comb begin
		ram_ext = '0;
		ram_ext[MSG_BITS-1:0] = ram_rdata;
	end

	pcmq_slot_table #(
		.SLOTS (SLOTS),
		.PW    (PW),
		.SW    (SW)
	) u_slots (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (st_we),
		.clr    (st_clr),
		.waddr  (st_waddr),
		.wowner (pid_q),
		.wwptr  (st_wwptr),
		.wrptr  (st_wrptr),
		.raddr  (raddr),
		.rowner (rowner),
		.rwptr  (rwptr),
		.rrptr  (rrptr)
	);

	pcmq_msg_ram #(
		.DEPTH    (DEPTH),
		.AW       (AW),
		.MSG_BITS (MSG_BITS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_base + AW'(wptr_q)),
		.wdata (msg_q),
		.re    (ram_re),
		.raddr (slot_base + AW'(rptr_q)),
		.rdata (ram_rdata)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q    <= req.op;
			pid_q   <= req.pid;
			msg_q   <= req.message[MSG_BITS-1:0];
			alive_q <= req.alive_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			idx_q     <= '0;
			pend_q    <= 1'b0;
			pidx_q    <= '0;
			slot_q    <= '0;
			found_q   <= 1'b0;
			wptr_q    <= '0;
			rptr_q    <= '0;
			status_q  <= pcmq_pkg::ST_OK;
			msg_out_q <= '0;
		end else begin
			if (scanning) begin
				if (rescan) begin
					idx_q <= '0;
				end else begin
					idx_q <= issue ? idx_q + CW'(1) : idx_q;
				end
				pend_q <= issue;
				pidx_q <= raddr;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						idx_q     <= '0;
						pend_q    <= 1'b0;
						found_q   <= 1'b0;
						msg_out_q <= '0;
						if (req.pid == '0) begin
							status_q <= pcmq_pkg::ST_PID_ZERO;
							state_q  <= S_OUT;
						end else begin
							state_q <= S_MATCH;
						end
					end
				end
				S_MATCH: begin
					if (pend_q) begin
						if (rowner == pid_q) begin
							slot_q  <= pidx_q;
							wptr_q  <= rwptr;
							rptr_q  <= rrptr;
							state_q <= S_ACT;
						end else if (last) begin
							if (op_q == pcmq_pkg::OP_PUSH) begin
								state_q <= S_RECLAIM;
							end else begin
								status_q <= pcmq_pkg::ST_UNKNOWN;
								state_q  <= S_OUT;
							end
						end
					end
				end
				S_RECLAIM: begin
					if (pend_q) begin
						if (free_now && !found_q) begin
							found_q <= 1'b1;
							slot_q  <= pidx_q;
						end
						if (last) begin
							if (found_q || free_now) begin
								wptr_q  <= '0;
								rptr_q  <= '0;
								state_q <= S_ACT;
							end else begin
								status_q <= pcmq_pkg::ST_NO_SLOT;
								state_q  <= S_OUT;
							end
						end
					end
				end
				S_ACT: begin
					if (op_q == pcmq_pkg::OP_PUSH) begin
						status_q <= full ? pcmq_pkg::ST_FULL : pcmq_pkg::ST_OK;
						state_q  <= S_OUT;
					end else if (empty) begin
						status_q <= pcmq_pkg::ST_EMPTY;
						state_q  <= S_OUT;
					end else begin
						status_q <= pcmq_pkg::ST_OK;
						state_q  <= S_POPWAIT;
					end
				end
				S_POPWAIT: begin
					msg_out_q <= ram_ext;
					state_q   <= S_OUT;
				end
				S_OUT: begin
					if (rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
